// ===== hw/rtl/qrv_pkg.sv =====
// Package with widths, constants and register indexes of the quaternion vector rotator.
`default_nettype none

package qrv_pkg;

	localparam int VEC_WIDTH  = 16;
	localparam int FRAC_BITS  = 14;
	localparam int QUAT_WIDTH = 16;
	localparam int OUT_WIDTH  = 18;

	localparam int P1_W  = QUAT_WIDTH + VEC_WIDTH;
	localparam int T_W   = P1_W + 2;
	localparam int P2_W  = T_W + QUAT_WIDTH;
	localparam int ACC_W = P2_W + 2;
	localparam int RND_W = ACC_W + 1;
	localparam int SH    = 2 * FRAC_BITS;

	localparam logic signed [QUAT_WIDTH-1:0] ROT_ONE = QUAT_WIDTH'(1) << FRAC_BITS;

	typedef enum logic [1:0] {
		REG_ROT_W = 2'd0,
		REG_ROT_X = 2'd1,
		REG_ROT_Y = 2'd2,
		REG_ROT_Z = 2'd3
	} cfg_idx_t;

endpackage

`default_nettype wire

// ===== hw/rtl/quaternion_rotate_vector.sv =====
// Quaternion vector rotator: five-stage pipeline computing q * v * conj(q).
// An accepted item passes the stage registers s1, s2, s3, s4 and s5 in order and leaves from s5.
// Throughput is one item per cycle; an output stall holds the full stages, empty ones still fill.
// Each stage holds one multiplier row, one adder row or the shift and clamp, so none is slower.
// Reset clears all valid bits and loads the identity quaternion (1.0, 0, 0, 0).
`default_nettype none

module quaternion_rotate_vector (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   cfg_valid,
	output logic                                        cfg_ready,
	input  wire qrv_pkg::cfg_idx_t                      cfg_index,
	input  wire logic signed [qrv_pkg::QUAT_WIDTH-1:0]  cfg_data,
	input  wire logic                                   in_valid,
	output logic                                        in_ready,
	input  wire logic signed [qrv_pkg::VEC_WIDTH-1:0]   vec_x,
	input  wire logic signed [qrv_pkg::VEC_WIDTH-1:0]   vec_y,
	input  wire logic signed [qrv_pkg::VEC_WIDTH-1:0]   vec_z,
	output logic                                        out_valid,
	input  wire logic                                   out_ready,
	output logic signed [qrv_pkg::OUT_WIDTH-1:0]        out_x,
	output logic signed [qrv_pkg::OUT_WIDTH-1:0]        out_y,
	output logic signed [qrv_pkg::OUT_WIDTH-1:0]        out_z,
	output logic                                        clipped
);
	import qrv_pkg::*;

	localparam logic signed [RND_W-1:0] RND    = RND_W'(1) << (SH - 1);
	localparam logic signed [RND_W-1:0] SAT_HI = RND_W'((1 << (OUT_WIDTH - 1)) - 1);
	localparam logic signed [RND_W-1:0] SAT_LO = -(RND_W'(1) << (OUT_WIDTH - 1));

	logic signed [QUAT_WIDTH-1:0] rot_w_q, rot_x_q, rot_y_q, rot_z_q;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic en_s1, en_s2, en_s3, en_s4, en_s5;

	logic signed [P1_W-1:0]      p1_s1 [12];
	logic signed [T_W-1:0]       tw_s2, tx_s2, ty_s2, tz_s2;
	logic signed [P2_W-1:0]      p2_s3 [12];
	logic signed [RND_W-1:0]     ax_s4, ay_s4, az_s4;

	logic signed [T_W-1:0]       tw_d, tx_d, ty_d, tz_d;
	logic signed [RND_W-1:0]     ax_d, ay_d, az_d;
	logic signed [RND_W-1:0]     sx_d, sy_d, sz_d;
	logic signed [OUT_WIDTH-1:0] ox_d, oy_d, oz_d;
	logic                        cx_d, cy_d, cz_d;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_w_q <= ROT_ONE;
			rot_x_q <= '0;
			rot_y_q <= '0;
			rot_z_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_ROT_W: rot_w_q <= cfg_data;
				REG_ROT_X: rot_x_q <= cfg_data;
				REG_ROT_Y: rot_y_q <= cfg_data;
				REG_ROT_Z: rot_z_q <= cfg_data;
				default:   rot_w_q <= rot_w_q;
			endcase
		end
	end

	assign en_s5    = !vld_s5 || out_ready;
	assign en_s4    = !vld_s4 || en_s5;
	assign en_s3    = !vld_s3 || en_s4;
	assign en_s2    = !vld_s2 || en_s3;
	assign en_s1    = !vld_s1 || en_s2;
	assign in_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			if (en_s1) vld_s1 <= in_valid;
			if (en_s2) vld_s2 <= vld_s1;
			if (en_s3) vld_s3 <= vld_s2;
			if (en_s4) vld_s4 <= vld_s3;
			if (en_s5) vld_s5 <= vld_s4;
		end
	end

	// Stage 1: products of the quaternion with the input vector.
	always_ff @(posedge clk) begin
		if (en_s1) begin
			p1_s1[0]  <= rot_x_q * vec_x;
			p1_s1[1]  <= rot_y_q * vec_y;
			p1_s1[2]  <= rot_z_q * vec_z;
			p1_s1[3]  <= rot_w_q * vec_x;
			p1_s1[4]  <= rot_y_q * vec_z;
			p1_s1[5]  <= rot_z_q * vec_y;
			p1_s1[6]  <= rot_w_q * vec_y;
			p1_s1[7]  <= rot_z_q * vec_x;
			p1_s1[8]  <= rot_x_q * vec_z;
			p1_s1[9]  <= rot_w_q * vec_z;
			p1_s1[10] <= rot_x_q * vec_y;
			p1_s1[11] <= rot_y_q * vec_x;
		end
	end

	// Stage 2: t = q * (0, v).
	always_comb begin
		tw_d = -p1_s1[0] - p1_s1[1] - p1_s1[2];
		tx_d = p1_s1[3] + p1_s1[4] - p1_s1[5];
		ty_d = p1_s1[6] + p1_s1[7] - p1_s1[8];
		tz_d = p1_s1[9] + p1_s1[10] - p1_s1[11];
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			tw_s2 <= tw_d;
			tx_s2 <= tx_d;
			ty_s2 <= ty_d;
			tz_s2 <= tz_d;
		end
	end

	// Stage 3: products of t with the conjugate quaternion.
	always_ff @(posedge clk) begin
		if (en_s3) begin
			p2_s3[0]  <= tx_s2 * rot_w_q;
			p2_s3[1]  <= tw_s2 * rot_x_q;
			p2_s3[2]  <= ty_s2 * rot_z_q;
			p2_s3[3]  <= tz_s2 * rot_y_q;
			p2_s3[4]  <= ty_s2 * rot_w_q;
			p2_s3[5]  <= tw_s2 * rot_y_q;
			p2_s3[6]  <= tz_s2 * rot_x_q;
			p2_s3[7]  <= tx_s2 * rot_z_q;
			p2_s3[8]  <= tz_s2 * rot_w_q;
			p2_s3[9]  <= tw_s2 * rot_z_q;
			p2_s3[10] <= tx_s2 * rot_y_q;
			p2_s3[11] <= ty_s2 * rot_x_q;
		end
	end

	// Stage 4: vector part of t * conj(q), with the rounding half added in.
	always_comb begin
		ax_d = p2_s3[0] - p2_s3[1] - p2_s3[2] + p2_s3[3] + RND;
		ay_d = p2_s3[4] - p2_s3[5] - p2_s3[6] + p2_s3[7] + RND;
		az_d = p2_s3[8] - p2_s3[9] - p2_s3[10] + p2_s3[11] + RND;
	end

	always_ff @(posedge clk) begin
		if (en_s4) begin
			ax_s4 <= ax_d;
			ay_s4 <= ay_d;
			az_s4 <= az_d;
		end
	end

	// Stage 5: shift out the fraction and saturate to the output width.
	always_comb begin
		sx_d = ax_s4 >>> SH;
		sy_d = ay_s4 >>> SH;
		sz_d = az_s4 >>> SH;
		cx_d = (sx_d > SAT_HI) || (sx_d < SAT_LO);
		cy_d = (sy_d > SAT_HI) || (sy_d < SAT_LO);
		cz_d = (sz_d > SAT_HI) || (sz_d < SAT_LO);
		ox_d = (sx_d > SAT_HI) ? SAT_HI[OUT_WIDTH-1:0] :
		       (sx_d < SAT_LO) ? SAT_LO[OUT_WIDTH-1:0] : sx_d[OUT_WIDTH-1:0];
		oy_d = (sy_d > SAT_HI) ? SAT_HI[OUT_WIDTH-1:0] :
		       (sy_d < SAT_LO) ? SAT_LO[OUT_WIDTH-1:0] : sy_d[OUT_WIDTH-1:0];
		oz_d = (sz_d > SAT_HI) ? SAT_HI[OUT_WIDTH-1:0] :
		       (sz_d < SAT_LO) ? SAT_LO[OUT_WIDTH-1:0] : sz_d[OUT_WIDTH-1:0];
	end

	always_ff @(posedge clk) begin
		if (en_s5) begin
			out_x   <= ox_d;
			out_y   <= oy_d;
			out_z   <= oz_d;
			clipped <= cx_d || cy_d || cz_d;
		end
	end

	assign out_valid = vld_s5;

endmodule

`default_nettype wire
